@@ hdl/cmd_pkg.sv @@
package cmd_pkg;
   localparam int COMPONENT_WIDTH = 32;
   localparam int FRACTION_BITS   = 16;

   localparam int W   = COMPONENT_WIDTH;
   localparam int F   = FRACTION_BITS;
   localparam int PW  = 2 * W;
   localparam int SW  = PW + 1;
   localparam int NW  = SW + F;
   localparam int DSW = SW + W;
   localparam int QW  = W + 1;

   localparam logic OP_MUL = 1'b0;
   localparam logic OP_DIV = 1'b1;

   typedef struct packed {
      logic           dz;
      logic           last;
      logic           neg_re;
      logic           neg_im;
      logic [NW-1:0]  r_re;
      logic [NW-1:0]  r_im;
      logic [DSW-1:0] dsh;
      logic [QW-1:0]  q_re;
      logic [QW-1:0]  q_im;
   } cell_type;
endpackage

@@ hdl/cmd_if.sv @@
interface cmd_req_if import cmd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic                op;
   logic signed [W-1:0] x_re;
   logic signed [W-1:0] x_im;
   logic signed [W-1:0] y_re;
   logic signed [W-1:0] y_im;
   logic                last_in;
   modport source (output valid, op, x_re, x_im, y_re, y_im, last_in, input ready);
   modport sink (input valid, op, x_re, x_im, y_re, y_im, last_in, output ready);
endinterface

interface cmd_rsp_if import cmd_pkg::*; ();
   logic                valid;
   logic                ready;
   logic signed [W-1:0] z_re;
   logic signed [W-1:0] z_im;
   logic                saturated;
   logic                divide_by_zero;
   logic                last_out;
   modport source (output valid, z_re, z_im, saturated, divide_by_zero, last_out,
                   input ready);
   modport sink (input valid, z_re, z_im, saturated, divide_by_zero, last_out,
                 output ready);
endinterface

@@ hdl/cmd_front.sv @@
module cmd_front import cmd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   cmd_req_if.sink  req,
   output logic     out_valid,
   output cell_type out_data,
   input  logic     out_ready
);
   logic                 v1_ff, v2_ff;
   logic                 op_ff, last_ff, dz_ff;
   logic signed [PW-1:0] rr_ff, ii_ff, ir_ff, ri_ff, sr_ff, si_ff;
   logic                 adv1, adv2;

   logic signed [SW-1:0] rr_x, ii_x, ir_x, ri_x, re_s, im_s;
   logic        [SW-1:0] den, mag_re, mag_im;
   cell_type             data_in, data_ff;

   assign adv2      = !v2_ff || out_ready;
   assign adv1      = !v1_ff || adv2;
   assign req.ready = adv1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv1) v1_ff <= req.valid;
         if (adv2) v2_ff <= v1_ff;
      end
      if (adv1 && req.valid) begin
         op_ff   <= req.op;
         last_ff <= req.last_in;
         dz_ff   <= (req.op == OP_DIV) && (req.y_re == '0) && (req.y_im == '0);
         rr_ff   <= PW'(req.x_re * req.y_re);
         ii_ff   <= PW'(req.x_im * req.y_im);
         ir_ff   <= PW'(req.x_im * req.y_re);
         ri_ff   <= PW'(req.x_re * req.y_im);
         sr_ff   <= PW'(req.y_re * req.y_re);
         si_ff   <= PW'(req.y_im * req.y_im);
      end
      if (adv2 && v1_ff) data_ff <= data_in;
   end

   always_comb begin
      rr_x = {rr_ff[PW-1], rr_ff};
      ii_x = {ii_ff[PW-1], ii_ff};
      ir_x = {ir_ff[PW-1], ir_ff};
      ri_x = {ri_ff[PW-1], ri_ff};
      den  = {1'b0, sr_ff} + {1'b0, si_ff};
      if (op_ff == OP_DIV) begin
         re_s = rr_x + ii_x;
         im_s = ir_x - ri_x;
      end else begin
         re_s = rr_x - ii_x;
         im_s = ir_x + ri_x;
      end
      mag_re = re_s[SW-1] ? SW'(-re_s) : SW'(re_s);
      mag_im = im_s[SW-1] ? SW'(-im_s) : SW'(im_s);
      data_in.dz     = dz_ff;
      data_in.last   = last_ff;
      data_in.neg_re = re_s[SW-1];
      data_in.neg_im = im_s[SW-1];
      data_in.q_re   = '0;
      data_in.q_im   = '0;
      if (op_ff == OP_DIV) begin
         data_in.r_re = NW'(mag_re) << F;
         data_in.r_im = NW'(mag_im) << F;
         data_in.dsh  = DSW'(den) << W;
      end else begin
         data_in.r_re = NW'(mag_re >> F);
         data_in.r_im = NW'(mag_im >> F);
         data_in.dsh  = DSW'(1) << W;
      end
   end

   assign out_valid = v2_ff;
   assign out_data  = data_ff;
endmodule

@@ hdl/cmd_cell.sv @@
module cmd_cell import cmd_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   input  cell_type in_data,
   output logic     in_ready,
   output logic     out_valid,
   output cell_type out_data,
   input  logic     out_ready
);
   logic     v_ff;
   cell_type data_ff, data_in;
   logic     bit_re, bit_im;

   assign in_ready = !v_ff || out_ready;

   always_comb begin
      data_in = in_data;
      bit_re  = DSW'(in_data.r_re) >= in_data.dsh;
      bit_im  = DSW'(in_data.r_im) >= in_data.dsh;
      if (bit_re) data_in.r_re = NW'(DSW'(in_data.r_re) - in_data.dsh);
      if (bit_im) data_in.r_im = NW'(DSW'(in_data.r_im) - in_data.dsh);
      data_in.q_re = {in_data.q_re[QW-2:0], bit_re};
      data_in.q_im = {in_data.q_im[QW-2:0], bit_im};
      data_in.dsh  = in_data.dsh >> 1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (in_ready) begin
         v_ff <= in_valid;
      end
      if (in_ready && in_valid) data_ff <= data_in;
   end

   assign out_valid = v_ff;
   assign out_data  = data_ff;
endmodule

@@ hdl/complex_multiply_divide.sv @@
// channel | dir | handshake     | payload
// req     | in  | valid / ready | op, x_re, x_im, y_re, y_im, last_in
// rsp     | out | valid / ready | z_re, z_im, saturated, divide_by_zero, last_out
//
// One item per cycle sustained while rsp.ready is high. Stages: two product
// and sum stages, one restoring division cell per quotient bit plus one
// overflow cell, and the output register. Multiply runs the same cells with
// a unit divisor. Synchronous reset clears all valid bits. Each stage holds
// its item while the next one is full, so bubbles close up under a stall.
module complex_multiply_divide import cmd_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   cmd_req_if.sink   req,
   cmd_rsp_if.source rsp
);
   localparam int NC = QW;

   logic     c_valid [NC+1];
   logic     c_ready [NC+1];
   cell_type c_data  [NC+1];

   cmd_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .out_valid (c_valid[0]),
      .out_data  (c_data[0]),
      .out_ready (c_ready[0])
   );

   for (genvar i = 0; i < NC; i++) begin : g_cell
      cmd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (c_valid[i]),
         .in_data   (c_data[i]),
         .in_ready  (c_ready[i]),
         .out_valid (c_valid[i+1]),
         .out_data  (c_data[i+1]),
         .out_ready (c_ready[i+1])
      );
   end

   logic                v_ff;
   logic signed [W-1:0] z_re_ff, z_im_ff, z_re_in, z_im_in;
   logic                sat_ff, dz_ff, last_ff, sat_in;
   logic        [W-1:0] lim_re, lim_im, m_re, m_im;
   logic                s_re, s_im;
   cell_type            fin;

   assign c_ready[NC] = !v_ff || rsp.ready;
   assign fin         = c_data[NC];

   always_comb begin
      lim_re = fin.neg_re ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      lim_im = fin.neg_im ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
      s_re   = fin.q_re[QW-1] || (fin.q_re[W-1:0] > lim_re);
      s_im   = fin.q_im[QW-1] || (fin.q_im[W-1:0] > lim_im);
      m_re   = s_re ? lim_re : fin.q_re[W-1:0];
      m_im   = s_im ? lim_im : fin.q_im[W-1:0];
      if (fin.dz) begin
         z_re_in = '0;
         z_im_in = '0;
         sat_in  = 1'b0;
      end else begin
         z_re_in = fin.neg_re ? $signed(-m_re) : $signed(m_re);
         z_im_in = fin.neg_im ? $signed(-m_im) : $signed(m_im);
         sat_in  = s_re || s_im;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (c_ready[NC]) begin
         v_ff <= c_valid[NC];
      end
      if (c_ready[NC] && c_valid[NC]) begin
         z_re_ff <= z_re_in;
         z_im_ff <= z_im_in;
         sat_ff  <= sat_in;
         dz_ff   <= fin.dz;
         last_ff <= fin.last;
      end
   end

   assign rsp.valid          = v_ff;
   assign rsp.z_re           = z_re_ff;
   assign rsp.z_im           = z_im_ff;
   assign rsp.saturated      = sat_ff;
   assign rsp.divide_by_zero = dz_ff;
   assign rsp.last_out       = last_ff;
endmodule
